### sv/tpba_pkg.sv
// Shared types and constants for the two-pool bitmap slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package tpba_pkg;

	localparam int SLOT_W     = 4;
	localparam int OFF_W      = 10;
	// Large slots are numbered from this value upwards.
	localparam int LARGE_BASE = 8;
	localparam int LOC_W      = 3;

	localparam logic MODE_ALLOC      = 1'b0;
	localparam logic MODE_FREE       = 1'b1;
	localparam logic CLASS_SMALL     = 1'b0;
	localparam logic CLASS_LARGE     = 1'b1;
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic              size_class;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] granted_slot;
		logic [OFF_W-1:0]  byte_offset;
	} rsp_t;

endpackage

`default_nettype wire

### sv/two_pool_bitmap_slot_allocator_top.sv
// Top level of the two-pool bitmap first-fit slot allocator.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------
// request   | in        | start high, busy low | req : mode, size_class, slot
// result    | out       | done strobe, 1 cycle | rsp : status, granted_slot,
//           |           |                      |       byte_offset
//
// One request per cycle. A request is registered into req_s1, where it is searched
// and committed against both busy bitmaps; its result is registered into rsp_q
// and shown there with done high.
// The bitmaps are updated at the same edge as rsp_q, so a following request already
// sees them; the single search stage sets the rate. busy stays low.
// Reset clears both bitmaps (every slot free) and the valid bits of the two
// stages. The receiver cannot stall: every result is shown for one cycle only.
module two_pool_bitmap_slot_allocator_top #(
	parameter int SMALL_SLOTS = 8,
	parameter int LARGE_SLOTS = 8,
	parameter int SMALL_BYTES = 32,
	parameter int LARGE_BYTES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire tpba_pkg::req_t req,
	output logic                done,
	output tpba_pkg::rsp_t      rsp
);

	import tpba_pkg::*;

	// Only slots below the numbering limit can ever be reached.
	localparam int NS = (SMALL_SLOTS < LARGE_BASE) ? SMALL_SLOTS : LARGE_BASE;
	localparam int NL = (LARGE_SLOTS < LARGE_BASE) ? LARGE_SLOTS : LARGE_BASE;
	// The large pool starts after the whole small pool, unused slots included.
	localparam int LARGE_START = SMALL_SLOTS * SMALL_BYTES;

	// Request stage.
	logic  vld_s1;
	req_t  req_s1;

	// Busy bitmaps.
	logic [NS-1:0] small_busy_q;
	logic [NL-1:0] large_busy_q;

	// Result register.
	logic  done_q;
	rsp_t  rsp_q;

	// Search results.
	logic             sm_found, lg_found, pr_found;
	logic [LOC_W-1:0] sm_loc, lg_loc, pr_loc;
	logic [NS-1:0]    sm_hot, pr_hot, sm_clr;
	logic [NL-1:0]    lg_hot, lg_clr;

	logic [NS-1:0] small_busy_d;
	logic [NL-1:0] large_busy_d;
	rsp_t          rsp_d;
	logic          fail;

	assign busy = 1'b0;

	// Register the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// First-fit priority encoders; scan downwards so the lowest fit wins.
	always_comb begin
		sm_found = 1'b0;
		sm_loc   = '0;
		sm_hot   = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (!small_busy_q[i]) begin
				sm_found  = 1'b1;
				sm_loc    = LOC_W'(i);
				sm_hot    = '0;
				sm_hot[i] = 1'b1;
			end
		end

		lg_found = 1'b0;
		lg_loc   = '0;
		lg_hot   = '0;
		for (int i = NL - 1; i >= 0; i--) begin
			if (!large_busy_q[i]) begin
				lg_found  = 1'b1;
				lg_loc    = LOC_W'(i);
				lg_hot    = '0;
				lg_hot[i] = 1'b1;
			end
		end

		// Adjacent free pair in the small pool for a spilled large item.
		pr_found = 1'b0;
		pr_loc   = '0;
		pr_hot   = '0;
		for (int i = NS - 2; i >= 0; i--) begin
			if (!small_busy_q[i] && !small_busy_q[i+1]) begin
				pr_found    = 1'b1;
				pr_loc      = LOC_W'(i);
				pr_hot      = '0;
				pr_hot[i]   = 1'b1;
				pr_hot[i+1] = 1'b1;
			end
		end
	end

	// Bits to drop on a free; slots outside the pools are ignored.
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			sm_clr[i] = !req_s1.slot[SLOT_W-1] &&
				((req_s1.slot[LOC_W-1:0] == LOC_W'(i)) ||
				 ((req_s1.size_class == CLASS_LARGE) &&
				  ({1'b0, req_s1.slot[LOC_W-1:0]} + 4'd1 == 4'(i))));
		end
		for (int i = 0; i < NL; i++) begin
			lg_clr[i] = req_s1.slot[SLOT_W-1] &&
				(req_s1.slot[LOC_W-1:0] == LOC_W'(i));
		end
	end

	// Grant selection and bitmap update.
	always_comb begin
		small_busy_d = small_busy_q;
		large_busy_d = large_busy_q;
		fail         = 1'b0;
		rsp_d.status       = STATUS_OK;
		rsp_d.granted_slot = '0;
		rsp_d.byte_offset  = '0;

		if (req_s1.mode == MODE_FREE) begin
			small_busy_d = small_busy_q & ~sm_clr;
			large_busy_d = large_busy_q & ~lg_clr;
		end else if (req_s1.size_class == CLASS_SMALL) begin
			if (sm_found) begin
				small_busy_d       = small_busy_q | sm_hot;
				rsp_d.granted_slot = {1'b0, sm_loc};
				rsp_d.byte_offset  = OFF_W'(32'(sm_loc) * 32'(SMALL_BYTES));
			end else if (lg_found) begin
				large_busy_d       = large_busy_q | lg_hot;
				rsp_d.granted_slot = {1'b1, lg_loc};
				rsp_d.byte_offset  = OFF_W'(32'(LARGE_START) +
					32'(lg_loc) * 32'(LARGE_BYTES));
			end else begin
				fail = 1'b1;
			end
		end else begin
			if (lg_found) begin
				large_busy_d       = large_busy_q | lg_hot;
				rsp_d.granted_slot = {1'b1, lg_loc};
				rsp_d.byte_offset  = OFF_W'(32'(LARGE_START) +
					32'(lg_loc) * 32'(LARGE_BYTES));
			end else if (pr_found) begin
				small_busy_d       = small_busy_q | pr_hot;
				rsp_d.granted_slot = {1'b0, pr_loc};
				rsp_d.byte_offset  = OFF_W'(32'(pr_loc) * 32'(SMALL_BYTES));
			end else begin
				fail = 1'b1;
			end
		end

		if (fail) begin
			rsp_d.status = STATUS_NO_SPACE;
		end
	end

	// Commit state and hold the result for its one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_busy_q <= '0;
			large_busy_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				small_busy_q <= small_busy_d;
				large_busy_q <= large_busy_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Every accepted request yields its result after the request stage and the result register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("request without result");

	// A failed allocation leaves both bitmaps untouched.
	a_fail_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && fail |=> $stable(small_busy_q) && $stable(large_busy_q))
		else $error("bitmap changed on failed allocation");

	// A free never marks a slot busy.
	a_free_only_clears: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && req_s1.mode == MODE_FREE |=>
		((small_busy_q & ~$past(small_busy_q)) == '0) &&
		((large_busy_q & ~$past(large_busy_q)) == '0))
		else $error("free set a busy bit");

	// A grant on the small pool leaves the large pool as it was, and vice versa.
	a_grant_one_pool: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && req_s1.mode == MODE_ALLOC |=>
		$stable(small_busy_q) || $stable(large_busy_q))
		else $error("allocation touched both pools");

endmodule

`default_nettype wire
